// ===== sv/hcp_pkg.sv =====
// Shared types, constants and fixed-point helpers for the HSL colorize pixel block.
`timescale 1ns / 1ps

package hcp_pkg;

  typedef logic [7:0]  byte_t;
  // Unsigned fraction with 16 fractional bits, range 0..1 inclusive.
  typedef logic [16:0] frac_t;
  // Hue in degrees with 8 fractional bits, 0..360 inclusive.
  typedef logic [16:0] hue_t;
  // One pixel, indexed by the channel codes below.
  typedef logic [2:0][7:0] pix_t;

  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  localparam logic [1:0] REG_HUE    = 2'd0;
  localparam logic [1:0] REG_SAT    = 2'd1;
  localparam logic [1:0] REG_WEIGHT = 2'd2;
  localparam logic [1:0] REG_FULL   = 2'd3;

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  localparam hue_t  HUE_60   = 17'd15360;
  localparam hue_t  HUE_120  = 17'd30720;
  localparam hue_t  HUE_180  = 17'd46080;
  localparam hue_t  HUE_240  = 17'd61440;
  localparam hue_t  HUE_360  = 17'd92160;
  localparam frac_t FRAC_ONE  = 17'd65536;
  localparam frac_t FRAC_HALF = 17'd32768;

  // hue*92160/255 = hue*361 + hue*7/17; the second term uses 7*3856 ~ 7*2^16/17.
  localparam logic [16:0] HUE_INT_MUL  = 17'd361;
  localparam logic [22:0] HUE_FRAC_MUL = 23'd26992;
  // Reciprocal of 15 scaled by 2^25, exact for dividends below 2^21.
  localparam logic [21:0] DIV15_MAGIC  = 22'd2236963;
  localparam int          DIV15_SHIFT  = 25;

  localparam logic [8:0] WEIGHT_FULL = 9'd256;

  // Segment of the hue ramp and the distance into the sloped part.
  typedef struct packed {
    logic [1:0]  seg;
    logic [13:0] span;
  } ramp_t;

  function automatic ramp_t hue_ramp_info(hue_t t);
    ramp_t r;
    hue_t  back;
    back = HUE_240 - t;
    if (t < HUE_60) begin
      r.seg  = SEG_RISE;
      r.span = t[13:0];
    end else if (t < HUE_180) begin
      r.seg  = SEG_HIGH;
      r.span = '0;
    end else if (t < HUE_240) begin
      r.seg  = SEG_FALL;
      r.span = back[13:0];
    end else begin
      r.seg  = SEG_LOW;
      r.span = '0;
    end
    return r;
  endfunction

  // floor(x * 65536 / 255): 65536 = 255*257 + 1, so only x = 255 gains one.
  function automatic frac_t byte_to_frac(byte_t x);
    return {1'b0, x, x} + {16'b0, (x == 8'hFF)};
  endfunction

  // floor(v * 255 / 65536) with v limited to one.
  function automatic byte_t frac_to_byte(frac_t v);
    frac_t       vc;
    logic [24:0] p;
    vc = (v > FRAC_ONE) ? FRAC_ONE : v;
    p  = {vc, 8'b0} - {8'b0, vc};
    return p[23:16];
  endfunction

endpackage

// ===== sv/hcp_pix_if.sv =====
// Valid/ready pixel channels: the input word and the result word.
`timescale 1ns / 1ps

interface hcp_in_if;
  logic            valid;
  logic            ready;
  hcp_pkg::byte_t  blue_in;
  hcp_pkg::byte_t  green_in;
  hcp_pkg::byte_t  red_in;

  modport source (output valid, output blue_in, output green_in, output red_in, input ready);
  modport sink   (input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface hcp_out_if;
  logic            valid;
  logic            ready;
  hcp_pkg::byte_t  blue_out;
  hcp_pkg::byte_t  green_out;
  hcp_pkg::byte_t  red_out;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  output ready);
endinterface

// ===== sv/hsl_colorize_pixel.sv =====
// Top level of the HSL colorize pixel pipeline.
`timescale 1ns / 1ps

// Recolors a stream of BGR pixels: each pixel keeps its HSL lightness and takes the
// programmed hue and saturation, then is either output as is or mixed with the
// original by the blend weight. The block takes one word per clock when not stalled
// and holds up to eight words in flight in eight register stages (lightness, fraction
// scaling, the lightness-saturation product, m1/m2, the ramp product, the divide by
// sixty degrees, byte conversion and the blend). The first stage loads at the
// accepting edge. Each stage stalls only when it is full and the stage after it
// cannot take its word, so bubbles close up under backpressure. The user must write
// registers only while no word is in flight; the block itself does not enforce it.
// Hue and saturation are converted into registered fixed-point forms after a write.

module hsl_colorize_pixel (
  input  logic              clk,
  input  logic              rst_n,
  hcp_in_if.sink            in_pix,
  hcp_out_if.source         out_pix,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam int NST = 7;

  // Configuration registers.
  logic [7:0] hue_r;
  logic [7:0] sat_r;
  logic [8:0] weight_r;
  logic       full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r    <= '0;
      sat_r    <= '0;
      weight_r <= hcp_pkg::WEIGHT_FULL;
      full_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcp_pkg::REG_HUE:    hue_r    <= cfg_data[7:0];
        hcp_pkg::REG_SAT:    sat_r    <= cfg_data[7:0];
        hcp_pkg::REG_WEIGHT: weight_r <= cfg_data;
        hcp_pkg::REG_FULL:   full_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Fixed-point forms of the hue and saturation, refreshed every clock.
  hcp_pkg::frac_t s_r, s_nxt;
  hcp_pkg::ramp_t ramp_r   [3];
  hcp_pkg::ramp_t ramp_nxt [3];
  logic [22:0]    hue_prod;
  hcp_pkg::hue_t  h_deg, t_red, t_blue;

  always_comb begin
    s_nxt    = hcp_pkg::byte_to_frac(sat_r);
    hue_prod = 23'(hue_r) * hcp_pkg::HUE_FRAC_MUL;
    h_deg    = 17'(hue_r) * hcp_pkg::HUE_INT_MUL + 17'(hue_prod[22:16]);
    t_red    = h_deg + hcp_pkg::HUE_120;
    if (t_red > hcp_pkg::HUE_360) begin
      t_red = t_red - hcp_pkg::HUE_360;
    end
    if (h_deg < hcp_pkg::HUE_120) begin
      t_blue = h_deg + hcp_pkg::HUE_240;
    end else begin
      t_blue = h_deg - hcp_pkg::HUE_120;
    end
    ramp_nxt[hcp_pkg::CH_RED]   = hcp_pkg::hue_ramp_info(t_red);
    ramp_nxt[hcp_pkg::CH_GREEN] = hcp_pkg::hue_ramp_info(h_deg);
    ramp_nxt[hcp_pkg::CH_BLUE]  = hcp_pkg::hue_ramp_info(t_blue);
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    ramp_r <= ramp_nxt;
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NST-1:0] vld_r;
  logic           out_vld_r;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_vld_r || out_pix.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_pix.ready  = en[0];
  assign out_pix.valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_pix.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (en[NST]) begin
        out_vld_r <= vld_r[NST-1];
      end
    end
  end

  // The original pixel rides along for the blend.
  hcp_pkg::pix_t old_r [NST];
  hcp_pkg::pix_t in_word;

  always_comb begin
    in_word[hcp_pkg::CH_BLUE]  = in_pix.blue_in;
    in_word[hcp_pkg::CH_GREEN] = in_pix.green_in;
    in_word[hcp_pkg::CH_RED]   = in_pix.red_in;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      old_r[0] <= in_word;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        old_r[k] <= old_r[k-1];
      end
    end
  end

  // Stage 0: lightness L = (max + min + 1) / 2.
  logic [7:0] mx, mn;
  logic [9:0] lum_sum;
  logic [7:0] lum0_r, lum0_nxt;

  always_comb begin
    mx = in_pix.blue_in;
    mn = in_pix.blue_in;
    if (in_pix.green_in > mx) mx = in_pix.green_in;
    if (in_pix.green_in < mn) mn = in_pix.green_in;
    if (in_pix.red_in > mx)   mx = in_pix.red_in;
    if (in_pix.red_in < mn)   mn = in_pix.red_in;
    lum_sum  = 10'(mx) + 10'(mn) + 10'd1;
    lum0_nxt = lum_sum[8:1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) lum0_r <= lum0_nxt;
  end

  // Stage 1: lightness as a fraction.
  hcp_pkg::frac_t l1_r;

  always_ff @(posedge clk) begin
    if (en[1]) l1_r <= hcp_pkg::byte_to_frac(lum0_r);
  end

  // Stage 2: l*s product.
  logic [33:0]    ls_prod;
  hcp_pkg::frac_t l2_r, ls2_r;

  assign ls_prod = 34'(l1_r) * 34'(s_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l2_r  <= l1_r;
      ls2_r <= ls_prod[32:16];
    end
  end

  // Stage 3: m2, m1 and their difference.
  logic [17:0]    m2_wide, m1_wide;
  hcp_pkg::frac_t m2_nxt, m1_nxt, d_nxt;
  hcp_pkg::frac_t m1_3_r, m2_3_r, d_3_r;

  always_comb begin
    if (l2_r <= hcp_pkg::FRAC_HALF) begin
      m2_wide = 18'(l2_r) + 18'(ls2_r);
    end else begin
      m2_wide = 18'(l2_r) + 18'(s_r) - 18'(ls2_r);
    end
    m1_wide = {l2_r, 1'b0} - m2_wide;
    m2_nxt  = m2_wide[16:0];
    m1_nxt  = m1_wide[16:0];
    d_nxt   = m2_nxt - m1_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m1_3_r <= m1_nxt;
      m2_3_r <= m2_nxt;
      d_3_r  <= d_nxt;
    end
  end

  // Stage 4: ramp product (m2 - m1) * offset for each channel.
  logic [30:0]    p4_r   [3];
  logic [30:0]    p4_nxt [3];
  logic [1:0]     seg4_r [3];
  hcp_pkg::frac_t m1_4_r, m2_4_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p4_nxt[c] = 31'(d_3_r) * 31'(ramp_r[c].span);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p4_r   <= p4_nxt;
      m1_4_r <= m1_3_r;
      m2_4_r <= m2_3_r;
      for (int c = 0; c < 3; c++) begin
        seg4_r[c] <= ramp_r[c].seg;
      end
    end
  end

  // Stage 5: divide by sixty degrees (1024 * 15) and add m1, or take m2 on the high segment.
  logic [20:0]    y5    [3];
  logic [42:0]    q5p   [3];
  hcp_pkg::frac_t q5    [3];
  hcp_pkg::frac_t v5_nxt [3];
  hcp_pkg::frac_t v5_r   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y5[c]  = p4_r[c][30:10];
      q5p[c] = 43'(y5[c]) * 43'(hcp_pkg::DIV15_MAGIC);
      q5[c]  = q5p[c][hcp_pkg::DIV15_SHIFT +: 17];
      if (seg4_r[c] == hcp_pkg::SEG_HIGH) begin
        v5_nxt[c] = m2_4_r;
      end else begin
        v5_nxt[c] = m1_4_r + q5[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) v5_r <= v5_nxt;
  end

  // Stage 6: back to bytes.
  hcp_pkg::pix_t nw6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        nw6_r[c] <= hcp_pkg::frac_to_byte(v5_r[c]);
      end
    end
  end

  // Output stage: direct or weighted mix with the original pixel.
  logic [8:0]    w_eff;
  logic [16:0]   mix [3];
  hcp_pkg::pix_t out_nxt, out_r;

  always_comb begin
    w_eff = (weight_r > hcp_pkg::WEIGHT_FULL) ? hcp_pkg::WEIGHT_FULL : weight_r;
    for (int c = 0; c < 3; c++) begin
      mix[c] = 17'(nw6_r[c]) * 17'(w_eff)
             + 17'(old_r[NST-1][c]) * 17'(hcp_pkg::WEIGHT_FULL - w_eff);
      out_nxt[c] = full_r ? nw6_r[c] : mix[c][15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) out_r <= out_nxt;
  end

  assign out_pix.blue_out  = out_r[hcp_pkg::CH_BLUE];
  assign out_pix.green_out = out_r[hcp_pkg::CH_GREEN];
  assign out_pix.red_out   = out_r[hcp_pkg::CH_RED];

  // The input side only stalls when every stage is full behind a held result.
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (out_vld_r && !out_pix.ready && (&vld_r)))
    else $error("input stalled without a held result");

  // m1 never exceeds m2 and the stored difference matches.
  a_m_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (m1_3_r <= m2_3_r) && (d_3_r == m2_3_r - m1_3_r))
    else $error("m1/m2 ordering broken");

  // Channel levels stay within one.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (v5_r[0] <= hcp_pkg::FRAC_ONE) && (v5_r[1] <= hcp_pkg::FRAC_ONE)
                 && (v5_r[2] <= hcp_pkg::FRAC_ONE))
    else $error("channel level above one");

  // A result only appears from a full last stage.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(vld_r[NST-1]))
    else $error("result word without a source");

endmodule
